### sv/htfc_pkg.sv
package htfc_pkg;

   localparam int BYTE_W  = 8;
   localparam int RAW_W   = 16;
   localparam int VALUE_W = 15;
   localparam int COEFF_W = 15;
   localparam int PROD_W  = RAW_W + COEFF_W;
   localparam int SUM_W   = VALUE_W + 1;
   localparam int CSR_INDEX_W = 1;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

   // conversion: value = offset + (coeff * raw) >> 16
   localparam logic [COEFF_W-1:0] TEMP_COEFF = 15'd17572;
   localparam logic [COEFF_W-1:0] HUM_COEFF  = 15'd12500;
   localparam logic signed [SUM_W-1:0] TEMP_OFFSET = -16'sd4685;
   localparam logic signed [SUM_W-1:0] HUM_OFFSET  = -16'sd600;
   localparam logic signed [SUM_W-1:0] HUM_MIN     = 16'sd0;
   localparam logic signed [SUM_W-1:0] HUM_MAX     = 16'sd10000;

   localparam logic signed [VALUE_W-1:0] TEMP_LOW_RESET  = -15'sd4000;
   localparam logic signed [VALUE_W-1:0] TEMP_HIGH_RESET = 15'sd12500;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMP_LOW  = 1'b0,
      CSR_TEMP_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CRC_BAD  = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      POS_MSB = 2'd0,
      POS_LSB = 2'd1,
      POS_CRC = 2'd2
   } pos_type;

   // one byte of crc-8, msb first
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### sv/htfc_if.sv
interface htfc_req_if;
   import htfc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] reply_byte;
   logic              frame_start;
   logic              is_humidity;

   modport source (output valid, output reply_byte, output frame_start,
                   output is_humidity, input ready);
   modport sink   (input valid, input reply_byte, input frame_start,
                   input is_humidity, output ready);
endinterface

interface htfc_rsp_if;
   import htfc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] measured_value;
   logic [RAW_W-1:0]          raw_reading;
   logic [1:0]                status;
   logic                      was_humidity;

   modport source (output valid, output measured_value, output raw_reading,
                   output status, output was_humidity, input ready);
   modport sink   (input valid, input measured_value, input raw_reading,
                   input status, input was_humidity, output ready);
endinterface

### sv/humidity_temp_frame_checker.sv
// Reply-frame checker for a humidity / temperature sensor. Takes the reply bytes
// MSB, LSB, CRC one transaction each at up to one byte per clock, runs a CRC-8
// (poly 0x31, init 0) over the two data bytes, and on the CRC byte emits one
// result: the raw 16-bit reading, the value in hundredths of a degree C or of
// percent RH (humidity clamped to 0..10000), and a status (ok, CRC mismatch,
// temperature outside the csr limits). A result is registered in the check stage
// (CRC check, byte assembly), then the result register (constant multiply,
// offset, clamp, limit compare). Data bytes give no result. The user writes
// csr_* limits only while no frame is in flight; the block does not enforce it.
module humidity_temp_frame_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   htfc_req_if.sink                                req_chan,
   htfc_rsp_if.source                              rsp_chan,
   input  logic                                    csr_wr_en,
   input  logic [htfc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [htfc_pkg::VALUE_W-1:0]            csr_wdata
);
   import htfc_pkg::*;

   // frame state
   pos_type           pos_ff, pos_in, pos_eff;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [BYTE_W-1:0] high_ff, high_in;
   logic [BYTE_W-1:0] low_ff, low_in;
   logic              kind_ff, kind_in;

   logic signed [VALUE_W-1:0] temp_low_ff, temp_high_ff;

   // check stage
   logic              s1_valid_ff, s1_valid_in;
   logic [RAW_W-1:0]  s1_raw_ff, s1_raw_in;
   logic              s1_kind_ff, s1_kind_in;
   logic              s1_crc_bad_ff, s1_crc_bad_in;

   // result register
   logic                      out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic [RAW_W-1:0]          out_raw_ff, out_raw_in;
   status_type                out_status_ff, out_status_in;
   logic                      out_kind_ff, out_kind_in;

   logic req_accept, out_adv, s1_adv;

   logic [COEFF_W-1:0]        coeff;
   logic [PROD_W-1:0]         prod;
   logic signed [SUM_W-1:0]   offset, sum, clamped;
   logic signed [SUM_W-1:0]   low_ext, high_ext;

   assign out_adv    = !out_valid_ff || rsp_chan.ready;
   assign s1_adv     = !s1_valid_ff || out_adv;
   assign req_chan.ready = s1_adv;
   assign req_accept = req_chan.valid && req_chan.ready;

   // byte assembly and running crc
   always_comb begin
      pos_eff       = req_chan.frame_start ? POS_MSB : pos_ff;
      kind_in       = req_chan.frame_start ? req_chan.is_humidity : kind_ff;
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      high_in       = high_ff;
      low_in        = low_ff;
      s1_raw_in     = {high_ff, low_ff};
      s1_kind_in    = kind_in;
      s1_crc_bad_in = (req_chan.reply_byte != crc_ff);
      s1_valid_in   = s1_valid_ff && !out_adv;
      if (!req_accept) begin
         kind_in = kind_ff;
      end else begin
         case (pos_eff)
            POS_LSB: begin
               low_in = req_chan.reply_byte;
               crc_in = crc8_byte(crc_ff, req_chan.reply_byte);
               pos_in = POS_CRC;
            end
            POS_CRC: begin
               pos_in      = POS_MSB;
               s1_valid_in = 1'b1;
            end
            default: begin
               // msb, also taken when no frame start was seen
               high_in = req_chan.reply_byte;
               crc_in  = crc8_byte(CRC_INIT, req_chan.reply_byte);
               pos_in  = POS_LSB;
            end
         endcase
      end
   end

   // conversion
   always_comb begin
      coeff    = s1_kind_ff ? HUM_COEFF : TEMP_COEFF;
      offset   = s1_kind_ff ? HUM_OFFSET : TEMP_OFFSET;
      prod     = PROD_W'(coeff) * PROD_W'(s1_raw_ff);
      sum      = offset + $signed({1'b0, prod[PROD_W-1:RAW_W]});
      clamped  = sum;
      if (s1_kind_ff) begin
         if (sum < HUM_MIN) begin
            clamped = HUM_MIN;
         end else if (sum > HUM_MAX) begin
            clamped = HUM_MAX;
         end
      end
      low_ext  = SUM_W'(temp_low_ff);
      high_ext = SUM_W'(temp_high_ff);

      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_value_in  = out_value_ff;
      out_raw_in    = out_raw_ff;
      out_status_in = out_status_ff;
      out_kind_in   = out_kind_ff;
      if (out_adv) begin
         out_valid_in = s1_valid_ff;
         out_value_in = clamped[VALUE_W-1:0];
         out_raw_in   = s1_raw_ff;
         out_kind_in  = s1_kind_ff;
         if (s1_crc_bad_ff) begin
            out_status_in = STATUS_CRC_BAD;
         end else if (!s1_kind_ff && (clamped < low_ext || clamped > high_ext)) begin
            out_status_in = STATUS_RANGE;
         end else begin
            out_status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_MSB;
         crc_ff        <= CRC_INIT;
         high_ff       <= '0;
         low_ff        <= '0;
         kind_ff       <= 1'b0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         temp_low_ff   <= TEMP_LOW_RESET;
         temp_high_ff  <= TEMP_HIGH_RESET;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         high_ff       <= high_in;
         low_ff        <= low_in;
         kind_ff       <= kind_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_TEMP_LOW:  temp_low_ff  <= csr_wdata;
               CSR_TEMP_HIGH: temp_high_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_raw_ff     <= s1_raw_in;
         s1_kind_ff    <= s1_kind_in;
         s1_crc_bad_ff <= s1_crc_bad_in;
      end
      out_value_ff  <= out_value_in;
      out_raw_ff    <= out_raw_in;
      out_status_ff <= out_status_in;
      out_kind_ff   <= out_kind_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.measured_value = out_value_ff;
   assign rsp_chan.raw_reading    = out_raw_ff;
   assign rsp_chan.status         = out_status_ff;
   assign rsp_chan.was_humidity   = out_kind_ff;

   // a crc byte always lands in the check stage
   a_crc_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_accept && pos_eff == POS_CRC) |=> s1_valid_ff)
      else $error("crc byte did not reach check stage");

   // a new result only follows a checked frame
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a checked frame");

   a_hum_clamped: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff) |->
         (out_value_ff >= HUM_MIN[VALUE_W-1:0] && out_value_ff <= HUM_MAX[VALUE_W-1:0]))
      else $error("humidity outside clamp range");

   a_hum_no_range_flag: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff) |-> (out_status_ff != STATUS_RANGE))
      else $error("humidity flagged out of range");

endmodule

### dv/tb_humidity_temp_frame_checker.sv
`timescale 1ns / 1ps

module tb_humidity_temp_frame_checker;
   import htfc_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 6;
   localparam int LONG_HOLD_OFF  = 400;
   localparam int BYTES_PER_PASS = 150;

   // conversion in hundredths: offset + (scale * raw) >> 16
   localparam int TEMP_SCALE  = 17572;
   localparam int TEMP_OFFS   = -4685;
   localparam int HUM_SCALE   = 12500;
   localparam int HUM_OFFS    = -600;
   localparam int HUM_CEILING = 10000;
   localparam int TEMP_FLOOR  = -4685;
   localparam int TEMP_CEIL   = 12887;
   localparam logic [7:0] CRC_SEED = 8'h00;
   localparam logic [7:0] CRC_GEN  = 8'h31;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       frame_start;
      logic       is_humidity;
   } frame_byte_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] measured_value;
      logic [RAW_W-1:0]          raw_reading;
      status_type                status;
      logic                      was_humidity;
   } reading_type;

   typedef enum logic [1:0] {
      SINK_EAGER,
      SINK_CHOPPY,
      SINK_SLUGGISH
   } sink_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [VALUE_W-1:0]     csr_wdata;

   htfc_req_if req_chan ();
   htfc_rsp_if rsp_chan ();

   humidity_temp_frame_checker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_byte_type bytes_to_send[$];
   reading_type    readings_due[$];

   // frame tracking state, mirrors the block
   logic [1:0]                frame_pos     = POS_MSB;
   logic [7:0]                crc_acc       = 8'h00;
   logic [7:0]                msb_latched   = 8'h00;
   logic [7:0]                lsb_latched   = 8'h00;
   logic                      kind_latched  = 1'b0;
   logic signed [VALUE_W-1:0] temp_low_lim  = -15'sd4000;
   logic signed [VALUE_W-1:0] temp_high_lim = 15'sd12500;

   int            mismatch_count = 0;
   int            cycle_count    = 0;
   logic          byte_taken     = 1'b0;
   int            burst_left     = 0;
   int            gap_left       = 0;
   int            hold_off_left  = 0;
   int            long_stalls_asked  = 0;
   int            long_stalls_served = 0;
   int            mode_left      = 0;
   sink_mode_type sink_mode      = SINK_EAGER;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [7:0] crc31_update(input logic [7:0] acc, input logic [7:0] din);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = acc[7] ^ din[i];
         acc = {acc[6:0], 1'b0};
         if (fb) begin
            acc = acc ^ CRC_GEN;
         end
      end
      return acc;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   task automatic predict_reply_byte(input frame_byte_type fb);
      int          scaled;
      logic [15:0] raw;
      reading_type due;
      if (fb.frame_start || frame_pos > POS_CRC) begin
         frame_pos = POS_MSB;
      end
      if (fb.frame_start) begin
         kind_latched = fb.is_humidity;
      end
      case (frame_pos)
         POS_MSB: begin
            msb_latched = fb.reply_byte;
            crc_acc     = crc31_update(CRC_SEED, fb.reply_byte);
            frame_pos   = POS_LSB;
         end
         POS_LSB: begin
            lsb_latched = fb.reply_byte;
            crc_acc     = crc31_update(crc_acc, fb.reply_byte);
            frame_pos   = POS_CRC;
         end
         default: begin
            raw = {msb_latched, lsb_latched};
            if (kind_latched) begin
               scaled = HUM_OFFS + ((HUM_SCALE * int'(raw)) >>> 16);
               if (scaled < 0) begin
                  scaled = 0;
               end
               if (scaled > HUM_CEILING) begin
                  scaled = HUM_CEILING;
               end
            end else begin
               scaled = TEMP_OFFS + ((TEMP_SCALE * int'(raw)) >>> 16);
            end
            // crc error wins over the range check
            if (fb.reply_byte != crc_acc) begin
               due.status = STATUS_CRC_BAD;
            end else if (!kind_latched && (scaled < int'(temp_low_lim) ||
                                           scaled > int'(temp_high_lim))) begin
               due.status = STATUS_RANGE;
            end else begin
               due.status = STATUS_OK;
            end
            due.measured_value = scaled[VALUE_W-1:0];
            due.raw_reading    = raw;
            due.was_humidity   = kind_latched;
            readings_due.push_back(due);
            frame_pos = POS_MSB;
         end
      endcase
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic start, input logic kind);
      frame_byte_type fb;
      fb.reply_byte  = b;
      fb.frame_start = start;
      fb.is_humidity = kind;
      bytes_to_send.push_back(fb);
   endtask

   task automatic queue_frame(input logic kind, input logic [15:0] raw, input logic start,
                              input logic crc_good);
      logic [7:0] crc;
      crc = crc31_update(crc31_update(CRC_SEED, raw[15:8]), raw[7:0]);
      if (!crc_good) begin
         crc = crc ^ 8'($urandom_range(1, 255));
      end
      queue_byte(raw[15:8], start, kind);
      queue_byte(raw[7:0], 1'b0, 1'($urandom_range(1)));
      queue_byte(crc, 1'b0, 1'($urandom_range(1)));
   endtask

   task automatic queue_random_traffic(input int n_bytes);
      int         queued;
      int         pick;
      int         len;
      logic [15:0] raw;
      queued = 0;
      while (queued < n_bytes) begin
         pick = $urandom_range(99);
         raw  = 16'($urandom_range(65535));
         len  = $urandom_range(9);
         // push some readings toward both ends of the scale
         if (len == 0) begin
            raw[15:8] = 8'h00;
         end else if (len == 1) begin
            raw[15:8] = 8'hFF;
         end
         if (pick < 75) begin
            queue_frame(1'($urandom_range(1)), raw, 1'b1, $urandom_range(99) < 85);
            queued += 3;
         end else if (pick < 83) begin
            queue_frame(1'($urandom_range(1)), raw, 1'b0, $urandom_range(99) < 85);
            queued += 3;
         end else if (pick < 93) begin
            // frame cut short, the next start restarts it
            len = $urandom_range(1, 2);
            queue_byte(raw[15:8], 1'b1, 1'($urandom_range(1)));
            if (len == 2) begin
               queue_byte(raw[7:0], 1'b0, 1'($urandom_range(1)));
            end
            queued += len;
         end else begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               queue_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                          1'($urandom_range(1)));
            end
            queued += len;
         end
      end
   endtask

   task automatic write_limit(input csr_index_type idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[VALUE_W-1:0];
      if (idx == CSR_TEMP_LOW) begin
         temp_low_lim = value[VALUE_W-1:0];
      end else begin
         temp_high_lim = value[VALUE_W-1:0];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (bytes_to_send.size() != 0 || readings_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_pass(input int low, input int high, input logic long_stall);
      write_limit(CSR_TEMP_LOW, low);
      write_limit(CSR_TEMP_HIGH, high);
      if (long_stall) begin
         long_stalls_asked++;
      end
      queue_random_traffic(BYTES_PER_PASS);
      wait_for_drain();
   endtask

   // request side: note each accepted transaction and predict from it
   always @(posedge clock) begin
      byte_taken = 1'b0;
      if (!reset && req_chan.valid && req_chan.ready) begin
         predict_reply_byte(bytes_to_send.pop_front());
         byte_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !byte_taken) begin
         // offered transaction still waiting, keep it steady
      end else if (gap_left > 0) begin
         gap_left--;
         req_chan.valid <= 1'b0;
      end else if (bytes_to_send.size() == 0) begin
         req_chan.valid <= 1'b0;
      end else begin
         req_chan.valid       <= 1'b1;
         req_chan.reply_byte  <= bytes_to_send[0].reply_byte;
         req_chan.frame_start <= bytes_to_send[0].frame_start;
         req_chan.is_humidity <= bytes_to_send[0].is_humidity;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end
   end

   // result side ready, with its own stall pattern
   always @(negedge clock) begin
      if (long_stalls_served < long_stalls_asked) begin
         long_stalls_served++;
         hold_off_left = LONG_HOLD_OFF;
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(2));
            mode_left = $urandom_range(4, 60);
         end
         mode_left--;
         case (sink_mode)
            SINK_EAGER:  rsp_chan.ready <= 1'b1;
            SINK_CHOPPY: rsp_chan.ready <= 1'($urandom_range(1));
            default:     rsp_chan.ready <= ($urandom_range(3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      reading_type due;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (readings_due.size() == 0) begin
            report_mismatch("unexpected result, raw_reading", rsp_chan.raw_reading, -1);
         end else begin
            due = readings_due.pop_front();
            if (rsp_chan.measured_value !== due.measured_value) begin
               report_mismatch("measured_value", int'(rsp_chan.measured_value),
                               int'(due.measured_value));
            end
            if (rsp_chan.raw_reading !== due.raw_reading) begin
               report_mismatch("raw_reading", rsp_chan.raw_reading, due.raw_reading);
            end
            if (rsp_chan.status !== due.status) begin
               report_mismatch("status", rsp_chan.status, due.status);
            end
            if (rsp_chan.was_humidity !== due.was_humidity) begin
               report_mismatch("was_humidity", rsp_chan.was_humidity, due.was_humidity);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out, %0d results still due", $time, readings_due.size());
         $display("** humidity_temp_frame_checker: FAILED **");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_TEMP_LOW;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.reply_byte  = '0;
      req_chan.frame_start = 1'b0;
      req_chan.is_humidity = 1'b0;
      rsp_chan.ready       = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames under the reset limits
      queue_frame(1'b0, 16'h0000, 1'b1, 1'b1);
      queue_frame(1'b0, 16'hFFFF, 1'b1, 1'b1);
      queue_frame(1'b1, 16'h0000, 1'b1, 1'b1);
      queue_frame(1'b1, 16'hFFFF, 1'b1, 1'b1);
      queue_frame(1'b0, 16'h6666, 1'b1, 1'b0);
      // restart in the middle of a frame
      queue_byte(8'hA5, 1'b1, 1'b0);
      queue_frame(1'b1, 16'h8001, 1'b1, 1'b1);
      // no start marker, humidity kind carried over
      queue_frame(1'b0, 16'h5A3C, 1'b0, 1'b1);
      queue_frame(1'b0, 16'h63F3, 1'b1, 1'b1);
      wait_for_drain();

      run_pass(TEMP_FLOOR, TEMP_CEIL, 1'b0);
      // low above high flags every temperature with a good CRC; receiver holds off meanwhile
      run_pass(TEMP_CEIL, TEMP_FLOOR, 1'b1);
      run_pass(0, 2500, 1'b0);
      run_pass($urandom_range(17572) + TEMP_FLOOR, $urandom_range(17572) + TEMP_FLOOR, 1'b0);
      run_pass(TEMP_FLOOR, TEMP_FLOOR, 1'b0);
      run_pass(-4000, 12500, 1'b0);

      if (mismatch_count == 0) begin
         $display("** humidity_temp_frame_checker: PASSED **");
      end else begin
         $display("** humidity_temp_frame_checker: FAILED **");
      end
      $finish;
   end

endmodule

### files.f
sv/htfc_pkg.sv
sv/htfc_if.sv
sv/humidity_temp_frame_checker.sv
dv/tb_humidity_temp_frame_checker.sv
